// ----- rtl/cfsa_pkg.sv -----
package cfsa_pkg;

	localparam int WORD_W        = 32;
	localparam int IDX_W         = 5;
	localparam int SLOT_W        = 10;
	localparam int CFG_W         = 11;
	localparam int MAX_SLOTS_DEF = 1024;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		logic              full_res;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIRST,
		ST_CHECK,
		ST_HOLD
	} state_t;

	// index of the lowest set bit of a map word, zero when none is set
	function automatic logic [IDX_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] iso;
		logic [IDX_W-1:0]  idx;
		iso = v & (~v + 1'b1);
		idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (iso[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- rtl/circular_free_slot_allocator.sv -----
// Allocate: one map read for the preferred word, then up to two reads of words picked
// from the non-empty summary, each a registered RAM read. Release: one map read, then
// a write, no result. One item in flight; the next is taken once it finishes,
// even while its result still waits in the output register.
// Reset clears control state and marks every slot free via per-word valid bits
// (no clearing pass); the managed count cfg_q resets to 1024.
module circular_free_slot_allocator #(
	parameter int MAX_SLOTS = cfsa_pkg::MAX_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  cfsa_pkg::req_t            req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output cfsa_pkg::rsp_t            rsp,
	input  logic                      cfg_we,
	input  logic [cfsa_pkg::CFG_W-1:0] cfg_wdata
);
	import cfsa_pkg::*;

	localparam int NW    = (MAX_SLOTS + WORD_W - 1) / WORD_W;
	localparam int AW    = (NW > 1) ? $clog2(NW) : 1;
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int CMPW  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	state_t            state_q, state_d;
	logic [CFG_W-1:0]  cfg_q;
	logic              op_q;
	logic [SLOT_W-1:0] slot_q;
	logic              rng_q;
	logic [AW-1:0]     cur_w_q, cur_w_d;
	logic              phase_q, phase_d;
	rsp_t              res_q, res_d;
	rsp_t              out_q, out_d;
	logic              out_valid_q;
	logic              ld_out;

	logic [CMPW-1:0]   n, nm1, req_ext, gidx;
	logic [AW-1:0]     last_w, req_w;
	logic              req_rng;
	logic              out_free;

	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [WORD_W-1:0] rd_data, wr_data;
	logic [NW-1:0]     summary;

	logic [WORD_W-1:0] hi_mask, m_first, m_chk, m_sel;
	logic [IDX_W-1:0]  g_bit;
	logic [NW-1:0]     sum_lim, sum_above, sum_low, iso_a, iso_l;
	logic [AW-1:0]     sa_idx, sl_idx;
	logic              fin;
	rsp_t              fin_res, grant_res;

	localparam rsp_t FULL_RES = '{granted_slot: '0, full_res: 1'b1};

	cfsa_map #(
		.NW(NW),
		.AW(AW)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.summary(summary)
	);

	// managed count saturates at the map depth
	always_comb begin
		n = (CMPW'(cfg_q) > CMPW'(MAX_SLOTS)) ? CMPW'(MAX_SLOTS) : CMPW'(cfg_q);
		nm1     = n - 1'b1;
		last_w  = nm1[IDX_W +: AW];
		req_ext = CMPW'(req.slot);
		req_w   = req_ext[IDX_W +: AW];
		req_rng = req_ext < n;
	end

	always_comb begin
		hi_mask = (cur_w_q == last_w) ?
			({WORD_W{1'b1}} >> (5'd31 - nm1[IDX_W-1:0])) : {WORD_W{1'b1}};
		m_first = rd_data & ({WORD_W{1'b1}} << slot_q[IDX_W-1:0]) & hi_mask;
		m_chk   = rd_data & hi_mask;
		m_sel   = (state_q == ST_FIRST) ? m_first : m_chk;
		g_bit   = lowest_bit(m_sel);
		gidx    = CMPW'({cur_w_q, g_bit});
		grant_res.granted_slot = gidx[SLOT_W-1:0];
		grant_res.full_res     = 1'b0;
	end

	// summary search: words up to the last managed one, and those above the current word
	always_comb begin
		sum_lim   = {NW{1'b1}} >> (AW'(NW - 1) - last_w);
		sum_low   = summary & sum_lim;
		sum_above = sum_low & (({NW{1'b1}} << cur_w_q) << 1);
		iso_a     = sum_above & (~sum_above + 1'b1);
		iso_l     = sum_low & (~sum_low + 1'b1);
		sa_idx    = '0;
		sl_idx    = '0;
		for (int i = 0; i < NW; i++) begin
			if (iso_a[i]) begin
				sa_idx = sa_idx | AW'(i);
			end
			if (iso_l[i]) begin
				sl_idx = sl_idx | AW'(i);
			end
		end
	end

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cur_w_d = cur_w_q;
		phase_d = phase_q;
		res_d   = res_q;
		rd_en   = 1'b0;
		rd_addr = cur_w_q;
		wr_en   = 1'b0;
		wr_addr = cur_w_q;
		wr_data = rd_data & ~(WORD_W'(1) << g_bit);
		ld_out  = 1'b0;
		out_d   = res_q;
		fin     = 1'b0;
		fin_res = FULL_RES;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					rd_en   = req_rng;
					rd_addr = req_w;
					cur_w_d = req_w;
					state_d = ST_FIRST;
				end
			end
			ST_FIRST: begin
				if (op_q == OP_RELEASE) begin
					wr_en   = rng_q;
					wr_data = rd_data | (WORD_W'(1) << slot_q[IDX_W-1:0]);
					state_d = ST_IDLE;
				end else if (n == '0) begin
					fin = 1'b1;
				end else if (rng_q && (|m_first)) begin
					wr_en   = 1'b1;
					fin     = 1'b1;
					fin_res = grant_res;
				end else if (rng_q && (|sum_above)) begin
					rd_en   = 1'b1;
					rd_addr = sa_idx;
					cur_w_d = sa_idx;
					phase_d = 1'b1;
					state_d = ST_CHECK;
				end else if (|sum_low) begin
					rd_en   = 1'b1;
					rd_addr = sl_idx;
					cur_w_d = sl_idx;
					phase_d = 1'b0;
					state_d = ST_CHECK;
				end else begin
					fin = 1'b1;
				end
			end
			ST_CHECK: begin
				// only the partly managed last word can come back empty
				if (|m_chk) begin
					wr_en   = 1'b1;
					fin     = 1'b1;
					fin_res = grant_res;
				end else if (phase_q && (|sum_low)) begin
					rd_en   = 1'b1;
					rd_addr = sl_idx;
					cur_w_d = sl_idx;
					phase_d = 1'b0;
				end else begin
					fin = 1'b1;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					ld_out  = 1'b1;
					out_d   = res_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fin) begin
			if (out_free) begin
				ld_out  = 1'b1;
				out_d   = fin_res;
				state_d = ST_IDLE;
			end else begin
				res_d   = fin_res;
				state_d = ST_HOLD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CFG_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q   <= req.opcode;
			slot_q <= req.slot;
			rng_q  <= req_rng;
		end
		cur_w_q <= cur_w_d;
		phase_q <= phase_d;
		res_q   <= res_d;
		if (ld_out) begin
			out_q <= out_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTHESIS
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("map read and write in the same cycle");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out && out_d.full_res |-> out_d.granted_slot == '0)
		else $error("full word carries a non-zero slot");

	a_grant_managed: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out && !out_d.full_res |-> CMPW'(out_d.granted_slot) < n)
		else $error("granted slot outside the managed range");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == ST_FIRST)
		else $error("accepted word did not start a map read");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_FIRST || state_q == ST_CHECK))
		else $error("map write outside a modify state");
`endif

endmodule

// ----- rtl/cfsa_map.sv -----
module cfsa_map #(
	parameter int NW = 32,
	parameter int AW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [cfsa_pkg::WORD_W-1:0] rd_data,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [cfsa_pkg::WORD_W-1:0] wr_data,
	output logic [NW-1:0]              summary
);
	import cfsa_pkg::*;

	logic [WORD_W-1:0] mem [NW];
	logic [WORD_W-1:0] rd_data_q;
	logic              rd_vld_q;
	logic [NW-1:0]     vld_q;
	logic [NW-1:0]     summary_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_vld_q  <= vld_q[rd_addr];
		end
	end

	// a word never written is all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			summary_q <= '1;
		end else if (wr_en) begin
			vld_q[wr_addr]     <= 1'b1;
			summary_q[wr_addr] <= |wr_data;
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '1;
	assign summary = summary_q;

endmodule
